>>> rtl/core/bfp_pkg.sv
// shared types, codes and the crc helper for the byte frame parser
package bfp_pkg;

	typedef enum logic [2:0] {
		PH_SOF0 = 3'd0,
		PH_SOF1 = 3'd1,
		PH_HEAD = 3'd2,
		PH_BODY = 3'd3,
		PH_CRCL = 3'd4,
		PH_CRCH = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_DATA = 3'd1,
		EV_GOOD = 3'd2,
		EV_CRC  = 3'd3,
		EV_LEN  = 3'd4,
		EV_DROP = 3'd5
	} event_t;

	localparam logic [1:0] REG_SOF_FIRST  = 2'd0;
	localparam logic [1:0] REG_SOF_SECOND = 2'd1;
	localparam logic [1:0] REG_PAY_LIMIT  = 2'd2;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [2:0]  HDR_LAST = 3'd4;

	typedef struct packed {
		event_t       ev;
		logic [7:0]   pay;
		logic [7:0]   version;
		logic [7:0]   kind;
		logic [7:0]   sequence_nr;
		logic [15:0]  length;
		logic [31:0]  good;
		logic [31:0]  crc_bad;
		logic [31:0]  len_bad;
		logic [31:0]  dropped;
	} result_t;

	// crc-16/modbus, one byte, lsb first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> rtl/core/byte_frame_parser_crc16_core.sv
// top level of the byte frame parser with crc-16 trailer check
//
// Input channel: one received byte per word on rx_byte, qualified by
// in_valid; the core drives in_stall. Output channel: one result word for
// every input word (event code, payload byte, latched header fields and
// four wrapping diagnostic counters), qualified by out_valid and held by
// out_stall from the receiver.
// An accepted word's result goes into the result register, or into the
// skid register while a result waits there. Throughput is one word per
// cycle while in_stall is low; the byte-wide crc update and the frame
// state step sit between the input and the result register. A two-entry
// output stage (result register plus skid register) lets the core take
// one more word while a result waits; in_stall rises once both are full.
// Configuration goes through the apb-style port at byte addresses 0, 4
// and 8; pready is always high and writes are meant for idle periods.
// Reset clears the frame state, counters and latched header fields and
// loads the default markers (0xaa, 0x55) and payload limit (1024).
module byte_frame_parser_crc16_core
	import bfp_pkg::*;
#(
	parameter int COUNTER_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [7:0]   rx_byte,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [2:0]   event_res,
	output logic [7:0]   payload_byte,
	output logic [7:0]   frame_version,
	output logic [7:0]   frame_kind,
	output logic [7:0]   frame_sequence,
	output logic [15:0]  hdr_length,
	output logic [31:0]  good_frames,
	output logic [31:0]  crc_failures,
	output logic [31:0]  length_failures,
	output logic [31:0]  dropped_bytes
);

	localparam logic [COUNTER_BITS-1:0] CNT_ONE = COUNTER_BITS'(1);

	// configuration
	logic [7:0]  sof_first_q, sof_second_q;
	logic [15:0] pay_limit_q;
	logic        cfg_wr;
	logic [1:0]  cfg_idx;

	// frame state
	phase_t      phase_q, phase_d;
	logic [2:0]  hpos_q, hpos_d;
	logic [7:0]  hdr_q [4];
	logic [15:0] ppos_q, ppos_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  trl_q, trl_d;
	logic [7:0]  ver_q, ver_d, kind_q, kind_d, seq_q, seq_d;
	logic [15:0] len_q, len_d;
	logic [COUNTER_BITS-1:0] good_q, good_d, crcf_q, crcf_d;
	logic [COUNTER_BITS-1:0] lenf_q, lenf_d, drop_q, drop_d;

	// output stage
	result_t     res_s1, skid_s1, res_d;
	logic        out_valid_q, skid_valid_q;
	logic        in_acc, out_take;

	logic [15:0] crc_next;
	logic [15:0] hdr_len;
	logic [15:0] ppos_inc;
	event_t      ev_d;
	logic [7:0]  pay_d;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (cfg_idx)
			REG_SOF_FIRST:  prdata = {24'h0, sof_first_q};
			REG_SOF_SECOND: prdata = {24'h0, sof_second_q};
			REG_PAY_LIMIT:  prdata = {16'h0, pay_limit_q};
			default:        prdata = 32'h0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sof_first_q  <= 8'hAA;
			sof_second_q <= 8'h55;
			pay_limit_q  <= 16'd1024;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_SOF_FIRST:  sof_first_q  <= pwdata[7:0];
				REG_SOF_SECOND: sof_second_q <= pwdata[7:0];
				REG_PAY_LIMIT:  pay_limit_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid && !skid_valid_q;
	assign out_take = out_valid_q && !out_stall;

	assign crc_next = crc16_byte(crc_q, rx_byte);
	assign hdr_len  = {rx_byte, hdr_q[3]};
	assign ppos_inc = ppos_q + 16'd1;

	always_comb begin
		phase_d = phase_q;
		hpos_d  = hpos_q;
		ppos_d  = ppos_q;
		crc_d   = crc_q;
		trl_d   = trl_q;
		ver_d   = ver_q;
		kind_d  = kind_q;
		seq_d   = seq_q;
		len_d   = len_q;
		good_d  = good_q;
		crcf_d  = crcf_q;
		lenf_d  = lenf_q;
		drop_d  = drop_q;
		ev_d    = EV_NONE;
		pay_d   = 8'h00;
		unique case (phase_q)
			PH_SOF0: begin
				if (rx_byte == sof_first_q) begin
					phase_d = PH_SOF1;
				end else begin
					ev_d   = EV_DROP;
					drop_d = drop_q + CNT_ONE;
				end
			end
			PH_SOF1: begin
				// second marker wins when both markers are equal
				if (rx_byte == sof_second_q) begin
					hpos_d  = 3'd0;
					crc_d   = CRC_INIT;
					phase_d = PH_HEAD;
				end else if (rx_byte != sof_first_q) begin
					ev_d    = EV_DROP;
					drop_d  = drop_q + CNT_ONE;
					phase_d = PH_SOF0;
				end
			end
			PH_HEAD: begin
				crc_d  = crc_next;
				hpos_d = hpos_q + 3'd1;
				if (hpos_q == HDR_LAST) begin
					ver_d  = hdr_q[0];
					kind_d = hdr_q[1];
					seq_d  = hdr_q[2];
					len_d  = hdr_len;
					hpos_d = 3'd0;
					if (hdr_len > pay_limit_q) begin
						ev_d    = EV_LEN;
						lenf_d  = lenf_q + CNT_ONE;
						phase_d = PH_SOF0;
						ppos_d  = 16'd0;
						trl_d   = 8'h00;
						crc_d   = CRC_INIT;
					end else if (hdr_len == 16'd0) begin
						phase_d = PH_CRCL;
					end else begin
						ppos_d  = 16'd0;
						phase_d = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				ev_d   = EV_DATA;
				pay_d  = rx_byte;
				crc_d  = crc_next;
				ppos_d = ppos_inc;
				if (ppos_inc >= len_q) begin
					phase_d = PH_CRCL;
				end
			end
			PH_CRCL: begin
				trl_d   = rx_byte;
				phase_d = PH_CRCH;
			end
			PH_CRCH: begin
				if (crc_q == {rx_byte, trl_q}) begin
					ev_d   = EV_GOOD;
					good_d = good_q + CNT_ONE;
				end else begin
					ev_d   = EV_CRC;
					crcf_d = crcf_q + CNT_ONE;
				end
				phase_d = PH_SOF0;
				hpos_d  = 3'd0;
				ppos_d  = 16'd0;
				trl_d   = 8'h00;
				crc_d   = CRC_INIT;
			end
			default: begin
				phase_d = PH_SOF0;
				hpos_d  = 3'd0;
				ppos_d  = 16'd0;
				trl_d   = 8'h00;
				crc_d   = CRC_INIT;
			end
		endcase
	end

	// counters wider or narrower than 32 bits show their low word
	function automatic logic [31:0] low_word(input logic [COUNTER_BITS-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[31:0];
	endfunction

	always_comb begin
		res_d.ev          = ev_d;
		res_d.pay         = pay_d;
		res_d.version     = ver_d;
		res_d.kind        = kind_d;
		res_d.sequence_nr = seq_d;
		res_d.length      = len_d;
		res_d.good        = low_word(good_d);
		res_d.crc_bad     = low_word(crcf_d);
		res_d.len_bad     = low_word(lenf_d);
		res_d.dropped     = low_word(drop_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SOF0;
			hpos_q  <= 3'd0;
			ppos_q  <= 16'd0;
			crc_q   <= CRC_INIT;
			trl_q   <= 8'h00;
			ver_q   <= 8'h00;
			kind_q  <= 8'h00;
			seq_q   <= 8'h00;
			len_q   <= 16'd0;
			good_q  <= '0;
			crcf_q  <= '0;
			lenf_q  <= '0;
			drop_q  <= '0;
			for (int i = 0; i < 4; i++) begin
				hdr_q[i] <= 8'h00;
			end
		end else if (in_acc) begin
			phase_q <= phase_d;
			hpos_q  <= hpos_d;
			ppos_q  <= ppos_d;
			crc_q   <= crc_d;
			trl_q   <= trl_d;
			ver_q   <= ver_d;
			kind_q  <= kind_d;
			seq_q   <= seq_d;
			len_q   <= len_d;
			good_q  <= good_d;
			crcf_q  <= crcf_d;
			lenf_q  <= lenf_d;
			drop_q  <= drop_d;
			if (phase_q == PH_HEAD && hpos_q != HDR_LAST) begin
				hdr_q[hpos_q[1:0]] <= rx_byte;
			end
		end
	end

	// output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_acc;
			end
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				res_s1 <= skid_s1;
			end else if (in_acc) begin
				res_s1 <= res_d;
			end
		end else if (in_acc) begin
			skid_s1 <= res_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign event_res       = res_s1.ev;
	assign payload_byte    = res_s1.pay;
	assign frame_version   = res_s1.version;
	assign frame_kind      = res_s1.kind;
	assign frame_sequence  = res_s1.sequence_nr;
	assign hdr_length      = res_s1.length;
	assign good_frames     = res_s1.good;
	assign crc_failures    = res_s1.crc_bad;
	assign length_failures = res_s1.len_bad;
	assign dropped_bytes   = res_s1.dropped;

	// the skid entry only fills behind a held result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid without a result in the output register");

	// a payload phase always has a non-zero latched length
	a_body_len: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (len_q != 16'd0 && ppos_q < len_q))
		else $error("payload phase with exhausted or zero length");

	// header position never runs past the last header byte
	a_hpos_range: assert property (@(posedge clk) disable iff (!arst_n)
		hpos_q <= HDR_LAST)
		else $error("header position out of range");

	// an accepted word with a free output stage goes straight into the output register
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !out_valid_q) |=> (out_valid_q && !skid_valid_q))
		else $error("accepted word did not reach the output register");

endmodule

>>> tb/sv/tb_byte_frame_parser_crc16_core.sv
// self-checking testbench for the byte frame parser with crc-16 trailer check
module tb_byte_frame_parser_crc16_core
	import bfp_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD = 6;
	localparam int TIMEOUT_CYCLES = 200000;
	localparam int LONG_HOLD = 300;
	localparam int REPORT_LIMIT = 10;

	logic clk = 1'b1;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] rx_byte = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] event_res;
	logic [7:0] payload_byte;
	logic [7:0] frame_version;
	logic [7:0] frame_kind;
	logic [7:0] frame_sequence;
	logic [15:0] hdr_length;
	logic [31:0] good_frames;
	logic [31:0] crc_failures;
	logic [31:0] length_failures;
	logic [31:0] dropped_bytes;

	byte_frame_parser_crc16_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.payload_byte(payload_byte),
		.frame_version(frame_version),
		.frame_kind(frame_kind),
		.frame_sequence(frame_sequence),
		.hdr_length(hdr_length),
		.good_frames(good_frames),
		.crc_failures(crc_failures),
		.length_failures(length_failures),
		.dropped_bytes(dropped_bytes)
	);

	always begin
		clk = 1'b1;
		#(HALF_PERIOD);
		clk = 1'b0;
		#(HALF_PERIOD);
	end

	// parser state as the testbench sees it
	logic [7:0] mk_first, mk_second;
	logic [15:0] len_limit;
	phase_t psr_phase;
	logic [2:0] hdr_idx;
	logic [7:0] hdr_bytes[5];
	logic [15:0] body_count;
	logic [15:0] crc_acc;
	logic [7:0] trl_low;
	logic [7:0] lat_version, lat_kind, lat_seq;
	logic [15:0] lat_len;
	logic [31:0] cnt_good, cnt_crc, cnt_len, cnt_drop;

	logic [7:0] rx_stream[$];
	result_t predicted_words[$];
	int fail_count = 0;
	int gap_max = 0;
	int stall_max = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_request = 1'b0;
	bit byte_taken = 1'b0;
	bit word_taken = 1'b0;

	function automatic logic [15:0] crc_modbus(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] c;
		c = acc ^ {8'h00, d};
		for (int k = 0; k < 8; k++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	function automatic void frame_restart();
		psr_phase = PH_SOF0;
		hdr_idx = '0;
		body_count = '0;
		trl_low = '0;
		crc_acc = CRC_INIT;
	endfunction

	function automatic void parser_reset();
		mk_first = 8'hAA;
		mk_second = 8'h55;
		len_limit = 16'd1024;
		foreach (hdr_bytes[i])
			hdr_bytes[i] = '0;
		{lat_version, lat_kind, lat_seq, lat_len} = '0;
		{cnt_good, cnt_crc, cnt_len, cnt_drop} = '0;
		frame_restart();
	endfunction

	// one byte in, one result word out
	function automatic result_t parse_byte(input logic [7:0] rx);
		result_t r;
		r = '0;
		r.ev = EV_NONE;
		case (psr_phase)
			PH_SOF0: begin
				if (rx == mk_first) begin
					psr_phase = PH_SOF1;
				end else begin
					r.ev = EV_DROP;
					cnt_drop++;
				end
			end
			PH_SOF1: begin
				// second marker checked first, so equal markers start a header
				if (rx == mk_second) begin
					hdr_idx = '0;
					crc_acc = CRC_INIT;
					psr_phase = PH_HEAD;
				end else if (rx != mk_first) begin
					r.ev = EV_DROP;
					cnt_drop++;
					psr_phase = PH_SOF0;
				end
			end
			PH_HEAD: begin
				hdr_bytes[hdr_idx] = rx;
				crc_acc = crc_modbus(crc_acc, rx);
				hdr_idx++;
				if (hdr_idx == 3'd5) begin
					lat_version = hdr_bytes[0];
					lat_kind = hdr_bytes[1];
					lat_seq = hdr_bytes[2];
					lat_len = {hdr_bytes[4], hdr_bytes[3]};
					hdr_idx = '0;
					if (lat_len > len_limit) begin
						r.ev = EV_LEN;
						cnt_len++;
						frame_restart();
					end else if (lat_len == 16'd0) begin
						psr_phase = PH_CRCL;
					end else begin
						body_count = '0;
						psr_phase = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				r.ev = EV_DATA;
				r.pay = rx;
				crc_acc = crc_modbus(crc_acc, rx);
				body_count++;
				if (body_count >= lat_len)
					psr_phase = PH_CRCL;
			end
			PH_CRCL: begin
				trl_low = rx;
				psr_phase = PH_CRCH;
			end
			PH_CRCH: begin
				if (crc_acc == {rx, trl_low}) begin
					r.ev = EV_GOOD;
					cnt_good++;
				end else begin
					r.ev = EV_CRC;
					cnt_crc++;
				end
				frame_restart();
			end
			default: begin
				frame_restart();
			end
		endcase
		r.version = lat_version;
		r.kind = lat_kind;
		r.sequence_nr = lat_seq;
		r.length = lat_len;
		r.good = cnt_good;
		r.crc_bad = cnt_crc;
		r.len_bad = cnt_len;
		r.dropped = cnt_drop;
		return r;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want)
			note_failure($sformatf("%s expected %0h, got %0h", name, want, got));
	endtask

	// driver: bytes change at the falling edge, held while stalled
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !byte_taken)) begin
			byte_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (rx_stream.size() > 0) begin
				rx_byte <= rx_stream.pop_front();
				in_valid <= 1'b1;
				gap_left = $urandom_range(0, gap_max);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: a fresh stall count per word, plus the occasional long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (word_taken) begin
				word_taken = 1'b0;
				stall_left = $urandom_range(0, stall_max);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// monitor: check the result word first, then predict the byte taken at this edge
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				word_taken = 1'b1;
				if (predicted_words.size() == 0) begin
					note_failure($sformatf("unexpected result word, event %0d", event_res));
				end else begin
					want = predicted_words.pop_front();
					check_field("event_res", 32'(want.ev), 32'(event_res));
					check_field("payload_byte", 32'(want.pay), 32'(payload_byte));
					check_field("frame_version", 32'(want.version), 32'(frame_version));
					check_field("frame_kind", 32'(want.kind), 32'(frame_kind));
					check_field("frame_sequence", 32'(want.sequence_nr),
						32'(frame_sequence));
					check_field("hdr_length", 32'(want.length), 32'(hdr_length));
					check_field("good_frames", want.good, good_frames);
					check_field("crc_failures", want.crc_bad, crc_failures);
					check_field("length_failures", want.len_bad, length_failures);
					check_field("dropped_bytes", want.dropped, dropped_bytes);
				end
			end
			if (in_valid && !in_stall) begin
				byte_taken = 1'b1;
				predicted_words.push_back(parse_byte(rx_byte));
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_SOF_FIRST: mk_first = value[7:0];
			REG_SOF_SECOND: mk_second = value[7:0];
			REG_PAY_LIMIT: len_limit = value[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_markers_and_limit(input logic [7:0] first, input logic [7:0] second,
			input logic [15:0] limit);
		write_reg(REG_SOF_FIRST, {24'h0, first});
		write_reg(REG_SOF_SECOND, {24'h0, second});
		write_reg(REG_PAY_LIMIT, {16'h0, limit});
	endtask

	// a frame under the current markers; a header over the limit stops after the header
	task automatic queue_frame(input logic [7:0] ver, input logic [7:0] kind,
			input logic [7:0] seq, input logic [15:0] len, input bit bad_crc,
			input int repeats, input int keep, input bit alt_pay);
		logic [7:0] bytes[$];
		logic [7:0] hdr[5];
		logic [7:0] pb;
		logic [15:0] crc;
		crc = CRC_INIT;
		repeat (repeats)
			bytes.push_back(mk_first);
		bytes.push_back(mk_first);
		bytes.push_back(mk_second);
		hdr = '{ver, kind, seq, len[7:0], len[15:8]};
		foreach (hdr[i]) begin
			bytes.push_back(hdr[i]);
			crc = crc_modbus(crc, hdr[i]);
		end
		if (len <= len_limit) begin
			for (int i = 0; i < int'(len); i++) begin
				pb = alt_pay ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom);
				bytes.push_back(pb);
				crc = crc_modbus(crc, pb);
			end
			if (bad_crc)
				crc ^= 16'($urandom_range(1, 16'hFFFF));
			bytes.push_back(crc[7:0]);
			bytes.push_back(crc[15:8]);
		end
		// cut short to leave a broken frame
		if (keep > 0)
			while (bytes.size() > keep)
				void'(bytes.pop_back());
		foreach (bytes[i])
			rx_stream.push_back(bytes[i]);
	endtask

	task automatic queue_random_traffic(input int target);
		int base, pick, lo, hi, repeats, keep;
		logic [15:0] len;
		base = rx_stream.size();
		while (rx_stream.size() - base < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				repeat ($urandom_range(1, 4))
					rx_stream.push_back(8'($urandom));
			end else begin
				len = 16'($urandom_range(0, (len_limit < 16'd12) ? int'(len_limit) : 12));
				if (pick < 25 && len_limit != 16'hFFFF) begin
					lo = int'(len_limit) + 1;
					hi = (lo + 3 > 65535) ? 65535 : lo + 3;
					len = (pick < 18) ? 16'hFFFF : 16'($urandom_range(lo, hi));
				end else if (pick < 32 && len_limit <= 16'd40) begin
					len = len_limit;
				end
				repeats = (mk_first != mk_second && pick % 3 == 0) ? $urandom_range(1, 2) : 0;
				keep = (pick >= 93 && len_limit <= 16'd1024) ? $urandom_range(1, 7) : 0;
				queue_frame(8'($urandom), 8'($urandom), 8'($urandom), len,
					pick >= 85 && pick < 93, repeats, keep, 1'b0);
			end
		end
	endtask

	task automatic wait_for_drain();
		while (rx_stream.size() != 0 || in_valid || predicted_words.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	initial begin
		#(2 * HALF_PERIOD * TIMEOUT_CYCLES);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		parser_reset();
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: drops, marker then junk, repeated first marker, empty frame,
		// short frame with extreme payload and a bad trailer
		gap_max = 2;
		stall_max = 2;
		rx_stream.push_back(8'h00);
		rx_stream.push_back(8'hFF);
		rx_stream.push_back(8'hAA);
		rx_stream.push_back(8'h00);
		queue_frame(8'hFF, 8'h00, 8'hFF, 16'd0, 1'b0, 1, 0, 1'b0);
		queue_frame(8'h00, 8'hFF, 8'h80, 16'd2, 1'b1, 0, 0, 1'b1);
		wait_for_drain();

		gap_max = 16;
		stall_max = 16;
		queue_random_traffic(65);
		wait_for_drain();

		// zero limit: only empty frames get through
		set_markers_and_limit(8'h00, 8'hFF, 16'd0);
		gap_max = 0;
		stall_max = 0;
		queue_random_traffic(65);
		wait_for_drain();

		set_markers_and_limit(8'h7E, 8'h7E, 16'd16);
		gap_max = 4;
		stall_max = 4;
		queue_random_traffic(65);
		wait_for_drain();

		set_markers_and_limit(8'hFF, 8'h00, 16'hFFFF);
		gap_max = 16;
		stall_max = 0;
		queue_random_traffic(65);
		wait_for_drain();

		// receiver holds off while the sender keeps offering words
		set_markers_and_limit(8'hAA, 8'h55, 16'd1);
		gap_max = 0;
		stall_max = 16;
		queue_random_traffic(65);
		@(posedge clk);
		hold_request = 1'b1;
		wait_for_drain();

		if (fail_count == 0 && predicted_words.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
